// ===== rtl/bph_pkg.sv =====
package bph_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int COUNT_W    = 10;
    localparam int LEVEL_W    = 16;
    localparam int STEP_W     = $clog2(LEVEL_W);
    localparam int SUM_W      = 25;
    localparam int DIVN_W     = COUNT_W + LEVEL_W;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 10'd1023;
    localparam logic [STEP_W-1:0]  STEP_LAST = STEP_W'(LEVEL_W - 1);

    typedef enum logic [1:0] {
        CMD_PIXEL    = 2'd0,
        CMD_READ_COL = 2'd1,
        CMD_READ_ROW = 2'd2,
        CMD_NONE     = 2'd3
    } cmd_t;

    localparam logic [1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [1:0] REG_FRAME_HEIGHT = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE   = 2'd2;
    localparam logic [1:0] REG_WHITE_LEVEL  = 2'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PIX,
        ST_PK_RD,
        ST_PK_CMP,
        ST_LV_RD,
        ST_LV_GET,
        ST_LV_DIV,
        ST_LV_USE,
        ST_MEAN_DIV,
        ST_MEAN_WAIT,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_SUM,
        PH_CNT,
        PH_READ
    } phase_t;

endpackage

// ===== rtl/bph_div.sv =====
module bph_div
    import bph_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DIVN_W-1:0]   num,
    input  logic [COUNT_W-1:0]  den,
    output logic                done,
    output logic [LEVEL_W-1:0]  quo
);

    logic                          busy_reg, busy_next;
    logic                          done_reg, done_next;
    logic [STEP_W-1:0]             step_reg, step_next;
    logic [COUNT_W-1:0]            rem_reg, rem_next;
    logic [LEVEL_W-1:0]            lo_reg, lo_next;
    logic [COUNT_W-1:0]            den_reg, den_next;
    logic [COUNT_W:0]              trial;
    logic [COUNT_W:0]              diff;
    logic                          ge;

    // One quotient bit per cycle; the dividend high part is below den.
    always_comb
    begin
        trial     = {rem_reg, lo_reg[LEVEL_W-1]};
        ge        = (trial >= {1'b0, den_reg});
        diff      = trial - {1'b0, den_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = num[DIVN_W-1:LEVEL_W];
            lo_next   = num[LEVEL_W-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? diff[COUNT_W-1:0] : trial[COUNT_W-1:0];
            lo_next   = {lo_reg[LEVEL_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        den_reg <= den_next;
    end

    assign done = done_reg;
    assign quo  = lo_reg;

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (num[DIVN_W-1:LEVEL_W] < den))
        else $error("divider quotient would overflow");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !start)
        else $error("divider restarted while busy");

    a_div_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy_reg && $past(busy_reg))
        else $error("divider done without a run");

endmodule

// ===== rtl/binary_projection_histogram_core.sv =====
// Binary projection histogram: per-column and per-row white-pixel counts.
// Commands enter on start/command/pixel_value/bin_index and are taken when
// start is high and busy is low. Config registers (width, height, full scale,
// white level) are written through cfg_we/cfg_addr/cfg_wdata by the user only
// while idle; the block does not enforce it. Each result shows on the result
// ports for one cycle with result_strobe; the receiver cannot stall, so
// nothing waits on it. A pixel is a read-modify-write of column count memory.
// The last pixel of a frame starts the summary walk: per axis a peak pass,
// a level-sum pass, one mean division and a threshold pass, where a bin level
// needs the 16-step serial divider when its count lies below a nonzero peak;
// the summary appears after this walk.
// A bin readout uses the same divider when its level needs it.
// A readout of an index beyond the current size answers the next cycle.
// Counts are cleared by fill marks reset at the first pixel of each frame,
// so reset needs no clearing pass: after reset all bins read zero.
module binary_projection_histogram_core
    import bph_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_addr,
    input  logic [9:0]          cfg_wdata,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          command,
    input  logic [7:0]          pixel_value,
    input  logic [8:0]          bin_index,
    output logic                result_strobe,
    output logic                result_kind,
    output logic [9:0]          bin_raw_count,
    output logic [15:0]         bin_level,
    output logic [9:0]          column_peak,
    output logic [9:0]          row_peak,
    output logic [7:0]          mean_column,
    output logic [7:0]          mean_row,
    output logic                motion_column,
    output logic                motion_row
);

    logic [COUNT_W-1:0] col_mem [MAX_WIDTH];
    logic [COUNT_W-1:0] row_mem [MAX_HEIGHT];
    logic [COUNT_W-1:0] col_rdata_reg, row_rdata_reg;
    logic [ADDR_W-1:0]  rd_addr;
    logic               col_we, row_we;
    logic [COUNT_W-1:0] col_wdata, row_wdata;

    logic [9:0] fw_reg, fh_reg;
    logic [7:0] fs_reg, wl_reg;

    state_t             state_reg, state_next;
    phase_t             ph_reg, ph_next;
    logic [ADDR_W-1:0]  x_reg, x_next, y_reg, y_next;
    logic [COUNT_W-1:0] run_reg, run_next;
    logic [COUNT_W-1:0] cfill_reg, cfill_next, rfill_reg, rfill_next;
    logic [COUNT_W-1:0] pkc_reg, pkc_next, pkr_reg, pkr_next;
    logic               ax_reg, ax_next;
    logic [COUNT_W-1:0] i_reg, i_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic [LEVEL_W-1:0] lvl_reg, lvl_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [COUNT_W-1:0] num_reg, num_next;
    logic [6:0]         thr_reg, thr_next;
    logic [7:0]         mc_reg, mc_next, mr_reg, mr_next;
    logic               vc_reg, vc_next, vr_reg, vr_next;
    logic               hit_reg, hit_next;

    logic               o_strobe_reg, o_strobe_next;
    logic               o_kind_reg, o_kind_next;
    logic [9:0]         o_raw_reg, o_raw_next;
    logic [15:0]        o_lvl_reg, o_lvl_next;
    logic [9:0]         o_pkc_reg, o_pkc_next, o_pkr_reg, o_pkr_next;
    logic [7:0]         o_mc_reg, o_mc_next, o_mr_reg, o_mr_next;
    logic               o_vc_reg, o_vc_next, o_vr_reg, o_vr_next;

    logic               div_start, div_done;
    logic [DIVN_W-1:0]  div_num;
    logic [COUNT_W-1:0] div_den;
    logic [LEVEL_W-1:0] div_quo;

    logic [9:0]         w_eff, h_eff, n_ax, fill_ax, peak_ax, q_ax, cnt_rd;
    logic [9:0]         i_inc, cur, newc, run_new, num_new, idx_ext;
    logic [9:0]         x_inc, y_inc;
    logic               i_last;
    logic [17:0]        prod;
    logic [15:0]        m_x205;
    logic [17:0]        n_x205;
    logic [8:0]         n_lim;
    logic [6:0]         thr_calc;

    bph_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quo   (div_quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg <= 10'd320;
            fh_reg <= 10'd240;
            fs_reg <= 8'd125;
            wl_reg <= 8'd255;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_FRAME_WIDTH:  fw_reg <= cfg_wdata;
                REG_FRAME_HEIGHT: fh_reg <= cfg_wdata;
                REG_FULL_SCALE:   fs_reg <= cfg_wdata[7:0];
                REG_WHITE_LEVEL:  wl_reg <= cfg_wdata[7:0];
            endcase
        end
    end

    always_comb
    begin
        if (fw_reg == '0)
            w_eff = 10'd1;
        else if (fw_reg > 10'(MAX_WIDTH))
            w_eff = 10'(MAX_WIDTH);
        else
            w_eff = fw_reg;
        if (fh_reg == '0)
            h_eff = 10'd1;
        else if (fh_reg > 10'(MAX_HEIGHT))
            h_eff = 10'(MAX_HEIGHT);
        else
            h_eff = fh_reg;
    end

    assign rd_addr = (state_reg == ST_IDLE) ? x_reg : i_reg[ADDR_W-1:0];

    always_ff @(posedge clk)
    begin
        col_rdata_reg <= col_mem[rd_addr];
        if (col_we)
            col_mem[x_reg] <= col_wdata;
    end

    always_ff @(posedge clk)
    begin
        row_rdata_reg <= row_mem[rd_addr];
        if (row_we)
            row_mem[y_reg] <= row_wdata;
    end

    always_comb
    begin
        n_ax     = ax_reg ? h_eff : w_eff;
        fill_ax  = ax_reg ? rfill_reg : cfill_reg;
        q_ax     = ax_reg ? row_rdata_reg : col_rdata_reg;
        peak_ax  = ax_reg ? pkr_reg : pkc_reg;
        // entries past the fill mark belong to an older frame: read them as zero
        cnt_rd   = (i_reg < fill_ax) ? q_ax : '0;
        i_inc    = i_reg + 10'd1;
        i_last   = !(i_inc < n_ax);
        prod     = cnt_rd * fs_reg;
        cur      = ({1'b0, x_reg} < cfill_reg) ? col_rdata_reg : '0;
        newc     = (hit_reg && cur != COUNT_MAX) ? cur + 10'd1 : cur;
        run_new  = (hit_reg && run_reg != COUNT_MAX) ? run_reg + 10'd1 : run_reg;
        x_inc    = {1'b0, x_reg} + 10'd1;
        y_inc    = {1'b0, y_reg} + 10'd1;
        num_new  = (lvl_reg > {1'b0, thr_reg, 8'h00}) ? num_reg + 10'd1 : num_reg;
        n_x205   = n_ax * 8'd205;
        n_lim    = 9'(n_x205[17:11] * 3'd7);
        m_x205   = div_quo[7:0] * 8'd205;
        thr_calc = 7'(m_x205[15:11] * 3'd5);
        idx_ext  = {1'b0, bin_index};
    end

    always_comb
    begin
        state_next    = state_reg;
        ph_next       = ph_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        run_next      = run_reg;
        cfill_next    = cfill_reg;
        rfill_next    = rfill_reg;
        pkc_next      = pkc_reg;
        pkr_next      = pkr_reg;
        ax_next       = ax_reg;
        i_next        = i_reg;
        cnt_next      = cnt_reg;
        lvl_next      = lvl_reg;
        sum_next      = sum_reg;
        num_next      = num_reg;
        thr_next      = thr_reg;
        mc_next       = mc_reg;
        mr_next       = mr_reg;
        vc_next       = vc_reg;
        vr_next       = vr_reg;
        hit_next      = hit_reg;
        o_strobe_next = 1'b0;
        o_kind_next   = o_kind_reg;
        o_raw_next    = o_raw_reg;
        o_lvl_next    = o_lvl_reg;
        o_pkc_next    = o_pkc_reg;
        o_pkr_next    = o_pkr_reg;
        o_mc_next     = o_mc_reg;
        o_mr_next     = o_mr_reg;
        o_vc_next     = o_vc_reg;
        o_vr_next     = o_vr_reg;
        col_we        = 1'b0;
        row_we        = 1'b0;
        col_wdata     = newc;
        row_wdata     = run_new;
        div_start     = 1'b0;
        div_num       = '0;
        div_den       = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd_t'(command))
                        CMD_PIXEL:
                        begin
                            // first pixel of a frame: drop all counts
                            if (x_reg == '0 && y_reg == '0)
                            begin
                                cfill_next = '0;
                                rfill_next = '0;
                                run_next   = '0;
                            end
                            hit_next   = (pixel_value == wl_reg);
                            state_next = ST_PIX;
                        end
                        CMD_READ_COL, CMD_READ_ROW:
                        begin
                            ax_next = (cmd_t'(command) == CMD_READ_ROW);
                            if (idx_ext < ((cmd_t'(command) == CMD_READ_ROW) ? h_eff : w_eff))
                            begin
                                i_next     = idx_ext;
                                ph_next    = PH_READ;
                                state_next = ST_LV_RD;
                            end
                            else
                            begin
                                o_strobe_next = 1'b1;
                                o_kind_next   = 1'b1;
                                o_raw_next    = '0;
                                o_lvl_next    = '0;
                                o_pkc_next    = pkc_reg;
                                o_pkr_next    = pkr_reg;
                                o_mc_next     = '0;
                                o_mr_next     = '0;
                                o_vc_next     = 1'b0;
                                o_vr_next     = 1'b0;
                            end
                        end
                        CMD_NONE:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_PIX:
            begin
                col_we = 1'b1;
                if ({1'b0, x_reg} == cfill_reg)
                    cfill_next = cfill_reg + 10'd1;
                if (x_inc < w_eff)
                begin
                    x_next     = x_inc[ADDR_W-1:0];
                    run_next   = run_new;
                    state_next = ST_IDLE;
                end
                else
                begin
                    row_we   = 1'b1;
                    if ({1'b0, y_reg} == rfill_reg)
                        rfill_next = rfill_reg + 10'd1;
                    run_next = '0;
                    x_next   = '0;
                    if (y_inc < h_eff)
                    begin
                        y_next     = y_inc[ADDR_W-1:0];
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        y_next     = '0;
                        ax_next    = 1'b0;
                        i_next     = '0;
                        pkc_next   = '0;
                        state_next = ST_PK_RD;
                    end
                end
            end
            ST_PK_RD:
            begin
                state_next = ST_PK_CMP;
            end
            ST_PK_CMP:
            begin
                if (cnt_rd > peak_ax)
                begin
                    if (ax_reg)
                        pkr_next = cnt_rd;
                    else
                        pkc_next = cnt_rd;
                end
                if (i_last)
                begin
                    i_next     = '0;
                    sum_next   = '0;
                    ph_next    = PH_SUM;
                    state_next = ST_LV_RD;
                end
                else
                begin
                    i_next     = i_inc;
                    state_next = ST_PK_RD;
                end
            end
            ST_LV_RD:
            begin
                state_next = ST_LV_GET;
            end
            ST_LV_GET:
            begin
                cnt_next = cnt_rd;
                priority if (peak_ax == '0)
                begin
                    lvl_next   = '0;
                    state_next = ST_LV_USE;
                end
                else if (cnt_rd >= peak_ax)
                begin
                    lvl_next   = {fs_reg, 8'h00};
                    state_next = ST_LV_USE;
                end
                else
                begin
                    div_start  = 1'b1;
                    div_num    = {prod, 8'h00};
                    div_den    = peak_ax;
                    state_next = ST_LV_DIV;
                end
            end
            ST_LV_DIV:
            begin
                if (div_done)
                begin
                    lvl_next   = div_quo;
                    state_next = ST_LV_USE;
                end
            end
            ST_LV_USE:
            begin
                unique case (ph_reg)
                    PH_READ:
                    begin
                        o_strobe_next = 1'b1;
                        o_kind_next   = 1'b1;
                        o_raw_next    = cnt_reg;
                        o_lvl_next    = lvl_reg;
                        o_pkc_next    = pkc_reg;
                        o_pkr_next    = pkr_reg;
                        o_mc_next     = '0;
                        o_mr_next     = '0;
                        o_vc_next     = 1'b0;
                        o_vr_next     = 1'b0;
                        state_next    = ST_IDLE;
                    end
                    PH_SUM:
                    begin
                        sum_next = sum_reg + SUM_W'(lvl_reg);
                        if (i_last)
                            state_next = ST_MEAN_DIV;
                        else
                        begin
                            i_next     = i_inc;
                            state_next = ST_LV_RD;
                        end
                    end
                    PH_CNT:
                    begin
                        num_next = num_new;
                        if (i_last)
                        begin
                            if (ax_reg)
                            begin
                                vr_next    = !({1'b0, n_lim} < num_new);
                                state_next = ST_DONE;
                            end
                            else
                            begin
                                vc_next    = !({1'b0, n_lim} < num_new);
                                ax_next    = 1'b1;
                                i_next     = '0;
                                pkr_next   = '0;
                                state_next = ST_PK_RD;
                            end
                        end
                        else
                        begin
                            i_next     = i_inc;
                            state_next = ST_LV_RD;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_MEAN_DIV:
            begin
                div_start  = 1'b1;
                div_num    = DIVN_W'(sum_reg[SUM_W-1:8]);
                div_den    = n_ax;
                state_next = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (div_done)
                begin
                    if (ax_reg)
                        mr_next = div_quo[7:0];
                    else
                        mc_next = div_quo[7:0];
                    thr_next   = thr_calc;
                    i_next     = '0;
                    num_next   = '0;
                    ph_next    = PH_CNT;
                    state_next = ST_LV_RD;
                end
            end
            ST_DONE:
            begin
                o_strobe_next = 1'b1;
                o_kind_next   = 1'b0;
                o_raw_next    = '0;
                o_lvl_next    = '0;
                o_pkc_next    = pkc_reg;
                o_pkr_next    = pkr_reg;
                o_mc_next     = mc_reg;
                o_mr_next     = mr_reg;
                o_vc_next     = vc_reg;
                o_vr_next     = vr_reg;
                state_next    = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ph_reg       <= PH_SUM;
            x_reg        <= '0;
            y_reg        <= '0;
            run_reg      <= '0;
            cfill_reg    <= '0;
            rfill_reg    <= '0;
            pkc_reg      <= '0;
            pkr_reg      <= '0;
            ax_reg       <= 1'b0;
            i_reg        <= '0;
            o_strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            ph_reg       <= ph_next;
            x_reg        <= x_next;
            y_reg        <= y_next;
            run_reg      <= run_next;
            cfill_reg    <= cfill_next;
            rfill_reg    <= rfill_next;
            pkc_reg      <= pkc_next;
            pkr_reg      <= pkr_next;
            ax_reg       <= ax_next;
            i_reg        <= i_next;
            o_strobe_reg <= o_strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        lvl_reg    <= lvl_next;
        sum_reg    <= sum_next;
        num_reg    <= num_next;
        thr_reg    <= thr_next;
        mc_reg     <= mc_next;
        mr_reg     <= mr_next;
        vc_reg     <= vc_next;
        vr_reg     <= vr_next;
        hit_reg    <= hit_next;
        o_kind_reg <= o_kind_next;
        o_raw_reg  <= o_raw_next;
        o_lvl_reg  <= o_lvl_next;
        o_pkc_reg  <= o_pkc_next;
        o_pkr_reg  <= o_pkr_next;
        o_mc_reg   <= o_mc_next;
        o_mr_reg   <= o_mr_next;
        o_vc_reg   <= o_vc_next;
        o_vr_reg   <= o_vr_next;
    end

    assign busy          = (state_reg != ST_IDLE);
    assign result_strobe = o_strobe_reg;
    assign result_kind   = o_kind_reg;
    assign bin_raw_count = o_raw_reg;
    assign bin_level     = o_lvl_reg;
    assign column_peak   = o_pkc_reg;
    assign row_peak      = o_pkr_reg;
    assign mean_column   = o_mc_reg;
    assign mean_row      = o_mr_reg;
    assign motion_column = o_vc_reg;
    assign motion_row    = o_vr_reg;

    a_summary_fields: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && !result_kind) |-> (bin_raw_count == '0 && bin_level == '0))
        else $error("frame summary carries bin fields");

    a_pix_from_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PIX) |-> ($past(state_reg) == ST_IDLE))
        else $error("pixel update entered from a busy state");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cfill_reg <= 10'(MAX_WIDTH)) && (rfill_reg <= 10'(MAX_HEIGHT)))
        else $error("fill mark past memory depth");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (result_strobe && result_kind) |-> (bin_level <= {fs_reg, 8'h00}))
        else $error("bin level above full scale");

endmodule
